// ----- design/range_minimum_segment_tree_assert.svh -----
// ----------------------------------------------------------------------------
// range minimum segment tree assertion macros
// concurrent assertion shorthands sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RANGE_MINIMUM_SEGMENT_TREE_ASSERT_SVH
`define RANGE_MINIMUM_SEGMENT_TREE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RMST_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define RMST_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/rmst_pkg.sv -----
// ----------------------------------------------------------------------------
// rmst_pkg
// shared item types, command codes and constants of the range minimum tree
// ----------------------------------------------------------------------------
`default_nettype none

package rmst_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 10;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // value of an empty range and of a node never written
  localparam logic signed [VAL_W-1:0] TOP_VALUE = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                    cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;
    logic [POS_W-1:0]        range_low;
    logic [POS_W-1:0]        range_high;
  } rmst_item_t;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
  } rmst_res_t;

endpackage

`default_nettype wire

// ----- design/rmst_ram.sv -----
// ----------------------------------------------------------------------------
// rmst_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- design/rmst_seq.sv -----
// ----------------------------------------------------------------------------
// rmst_seq
// sequencer: clearing pass, leaf-to-root update walk and range query walk
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_seq #(
  parameter int LEAVES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  rmst_pkg::rmst_item_t          in_item,
  output logic                          in_stall,
  output rmst_pkg::rmst_res_t           res,
  input  logic                          res_ready,
  output logic                          mem_we,
  output logic [$clog2(2*LEAVES)-1:0]   mem_waddr,
  output logic [rmst_pkg::VAL_W-1:0]    mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(2*LEAVES)-1:0]   mem_raddr,
  input  logic [rmst_pkg::VAL_W-1:0]    mem_rdata
);

  import rmst_pkg::*;

  localparam int AW = $clog2(2*LEAVES);
  localparam int IW = $clog2(2*LEAVES+1);
  localparam int CW = (IW > POS_W) ? IW : POS_W;

  localparam logic [AW-1:0] NODE_LAST = AW'(2*LEAVES-1);
  localparam logic [AW-1:0] NODE_ROOT = AW'(1);
  localparam logic [AW-1:0] LEAF_AW   = AW'(LEAVES);
  localparam logic [IW-1:0] LEAF_IW   = IW'(LEAVES);
  localparam logic [CW-1:0] LEAF_CW   = CW'(LEAVES);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_LEAF = 3'd2;
  localparam logic [2:0] ST_UP   = 3'd3;
  localparam logic [2:0] ST_QL   = 3'd4;
  localparam logic [2:0] ST_QR   = 3'd5;
  localparam logic [2:0] ST_RES  = 3'd6;

  function automatic logic signed [VAL_W-1:0] min_val(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  logic [2:0]              state_r, state_nxt;
  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]           node_r, node_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    upd_ok_r, upd_ok_nxt;
  logic [IW-1:0]           left_r, left_nxt;
  logic [IW-1:0]           right_r, right_nxt;
  logic signed [VAL_W-1:0] best_r, best_nxt;
  logic                    rd_pend_r, rd_pend_nxt;

  logic signed [VAL_W-1:0] rdata_s;
  logic [AW-1:0]           parent;
  logic signed [VAL_W-1:0] up_min;
  logic [IW-1:0]           right_dec;
  logic [CW-1:0]           pos_c, lo_c, hi_c, hi_clip;

  assign rdata_s   = $signed(mem_rdata);
  assign parent    = node_r >> 1;
  assign up_min    = min_val(val_r, rdata_s);
  assign right_dec = right_r - IW'(1);
  assign pos_c     = CW'(in_item.position);
  assign lo_c      = CW'(in_item.range_low);
  assign hi_c      = CW'(in_item.range_high);
  assign hi_clip   = (hi_c >= LEAF_CW) ? (LEAF_CW - CW'(1)) : hi_c;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    node_nxt    = node_r;
    val_nxt     = val_r;
    upd_ok_nxt  = upd_ok_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    rd_pend_nxt = 1'b0;
    // fold in the node read issued last cycle
    best_nxt    = rd_pend_r ? min_val(best_r, rdata_s) : best_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    res.valid   = 1'b0;
    res.value   = best_r;

    case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = TOP_VALUE;
        if (clr_cnt_r == NODE_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_item.cmd == CMD_UPDATE) begin
            upd_ok_nxt = (pos_c < LEAF_CW);
            node_nxt   = AW'(pos_c) + LEAF_AW;
            val_nxt    = in_item.new_value;
            state_nxt  = ST_LEAF;
          end else begin
            best_nxt = TOP_VALUE;
            if ((lo_c > hi_c) || (lo_c >= LEAF_CW)) begin
              state_nxt = ST_RES;
            end else begin
              left_nxt  = IW'(lo_c) + LEAF_IW;
              right_nxt = IW'(hi_clip) + LEAF_IW + IW'(1);
              state_nxt = ST_QL;
            end
          end
        end
      end
      ST_LEAF: begin
        if (upd_ok_r) begin
          mem_we    = 1'b1;
          mem_waddr = node_r;
          mem_wdata = val_r;
          mem_re    = 1'b1;
          mem_raddr = node_r ^ AW'(1);
          state_nxt = ST_UP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_UP: begin
        // sibling data is back: write parent, fetch the parent's sibling unless the parent is the root
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_min;
        val_nxt   = up_min;
        node_nxt  = parent;
        if (parent == NODE_ROOT) begin
          state_nxt = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent ^ AW'(1);
        end
      end
      ST_QL: begin
        if (left_r >= right_r) begin
          state_nxt = ST_RES;
        end else begin
          if (left_r[0]) begin
            mem_re      = 1'b1;
            mem_raddr   = AW'(left_r);
            rd_pend_nxt = 1'b1;
            left_nxt    = left_r + IW'(1);
          end
          state_nxt = ST_QR;
        end
      end
      ST_QR: begin
        if (right_r[0]) begin
          mem_re      = 1'b1;
          mem_raddr   = AW'(right_dec);
          rd_pend_nxt = 1'b1;
          right_nxt   = right_dec >> 1;
        end else begin
          right_nxt = right_r >> 1;
        end
        left_nxt  = left_r >> 1;
        state_nxt = ST_QL;
      end
      ST_RES: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_cnt_r <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r   <= node_nxt;
    val_r    <= val_nxt;
    upd_ok_r <= upd_ok_nxt;
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    best_r   <= best_nxt;
  end

endmodule

`default_nettype wire

// ----- design/range_minimum_segment_tree.sv -----
// update: leaf write, then a walk up to the root with in_stall high, no result item
// query: a walk up the tree levels from both range ends, then to the result register
// one item at a time; the single read port of the node memory sets the pace
// reset: clearing pass writes all 2 * LEAVES nodes to max value, with in_stall
// high throughout; the result register comes out of reset empty
// ----------------------------------------------------------------------------
// range_minimum_segment_tree
// segment tree over LEAVES signed values: point update, inclusive range minimum
// ----------------------------------------------------------------------------
`default_nettype none

module range_minimum_segment_tree #(
  parameter int LEAVES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input item channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [rmst_pkg::POS_W-1:0]         in_position,
  input  logic signed [rmst_pkg::VAL_W-1:0]  in_new_value,
  input  logic [rmst_pkg::POS_W-1:0]         in_range_low,
  input  logic [rmst_pkg::POS_W-1:0]         in_range_high,
  // result item channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rmst_pkg::VAL_W-1:0]  out_minimum
);

  import rmst_pkg::*;

  // node memory: node 1 is the root, node LEAVES + p the leaf of position p
  localparam int DEPTH = 2*LEAVES;
  localparam int AW    = $clog2(DEPTH);

  rmst_item_t item;
  rmst_res_t  res;
  logic       res_ready;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [VAL_W-1:0]  mem_rdata;

  // output register, lets the tree move on while a result item waits
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_minimum_r, out_minimum_nxt;

  assign item.cmd        = in_cmd;
  assign item.position   = in_position;
  assign item.new_value  = in_new_value;
  assign item.range_low  = in_range_low;
  assign item.range_high = in_range_high;

  // the sequencer may hand over its result when the register is empty or draining
  assign res_ready = !out_valid_r || !out_stall;

  rmst_seq #(
    .LEAVES (LEAVES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (item),
    .in_stall  (in_stall),
    .res       (res),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rmst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_minimum_nxt = out_minimum_r;
    if (res.valid && res_ready) begin
      // new result loads the empty register or replaces the one taken in this cycle
      out_valid_nxt   = 1'b1;
      out_minimum_nxt = res.value;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_minimum_r <= out_minimum_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_minimum = out_minimum_r;

endmodule

`default_nettype wire

// ----- design/rmst_checker.sv -----
// ----------------------------------------------------------------------------
// rmst_checker
// port-level checks of the range minimum tree, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "range_minimum_segment_tree_assert.svh"

module rmst_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic signed [rmst_pkg::VAL_W-1:0]  out_minimum
);

  // a stalled result item stays
  `RMST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result item dropped")
  // and its value holds
  `RMST_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_minimum), "result changed")
  // every accepted item leaves the block busy in the next cycle
  `RMST_ASSERT_NEXT(a_busy_after_item, in_valid && !in_stall, in_stall, "not busy after item")
  // leaving reset starts the clearing pass with no result pending
  `RMST_ASSERT_SAME(a_reset_clear, $rose(rst_n), in_stall && !out_valid, "bad reset state")

endmodule

bind range_minimum_segment_tree rmst_checker u_rmst_checker (.*);

`default_nettype wire

// ----- bench/rmst_min_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_min_checker
// shadows the segment tree from accepted items and checks every minimum
// ----------------------------------------------------------------------------

module rmst_min_checker #(
  parameter int LEAVES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [rmst_pkg::POS_W-1:0]         in_position,
  input  logic signed [rmst_pkg::VAL_W-1:0]  in_new_value,
  input  logic [rmst_pkg::POS_W-1:0]         in_range_low,
  input  logic [rmst_pkg::POS_W-1:0]         in_range_high,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [rmst_pkg::VAL_W-1:0]  out_minimum,
  output int                                 mismatch_count,
  output int                                 minimums_waiting,
  output int                                 minimums_matched
);

  import rmst_pkg::*;

  logic signed [VAL_W-1:0] tree_shadow [2*LEAVES];
  logic signed [VAL_W-1:0] expected_minimums [$];
  int                      errs;
  int                      matched;

  initial begin
    errs    = 0;
    matched = 0;
  end

  function automatic void shadow_write(input int unsigned pos,
                                       input logic signed [VAL_W-1:0] value);
    int unsigned node;
    if (pos >= LEAVES) return;
    node = LEAVES + pos;
    tree_shadow[node] = value;
    while (node > 1) begin
      node = node >> 1;
      tree_shadow[node] = (tree_shadow[2*node] < tree_shadow[2*node+1]) ?
                          tree_shadow[2*node] : tree_shadow[2*node+1];
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] shadow_range_min(input int unsigned lo,
                                                               input int unsigned hi);
    logic signed [VAL_W-1:0] best;
    int unsigned             left;
    int unsigned             right;
    best = TOP_VALUE;
    if (lo > hi || lo >= LEAVES) return TOP_VALUE;
    if (hi >= LEAVES) hi = LEAVES - 1;
    left  = lo + LEAVES;
    right = hi + LEAVES + 1;
    while (left < right) begin
      if ((left & 1) != 0) begin
        if (tree_shadow[left] < best) best = tree_shadow[left];
        left++;
      end
      if ((right & 1) != 0) begin
        right--;
        if (tree_shadow[right] < best) best = tree_shadow[right];
      end
      left  = left >> 1;
      right = right >> 1;
    end
    return best;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2*LEAVES; i++) tree_shadow[i] = TOP_VALUE;
      expected_minimums.delete();
    end else begin
      // results first: a query cannot answer in the cycle it is taken
      if (out_valid && !out_stall) begin
        if (expected_minimums.size() == 0) begin
          $display("%0t: minimum with nothing expected, expected none, actual %0d",
                   $time, out_minimum);
          errs++;
        end else if (out_minimum !== expected_minimums[0]) begin
          $display("%0t: minimum mismatch, expected %0d, actual %0d",
                   $time, expected_minimums[0], out_minimum);
          errs++;
          void'(expected_minimums.pop_front());
        end else begin
          matched++;
          void'(expected_minimums.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        if (in_cmd == CMD_UPDATE) shadow_write(32'(in_position), in_new_value);
        else expected_minimums.insert(expected_minimums.size(),
               shadow_range_min(32'(in_range_low), 32'(in_range_high)));
      end
    end
    mismatch_count   <= errs;
    minimums_matched <= matched;
    minimums_waiting <= expected_minimums.size();
  end

endmodule

// ----- bench/tb_range_minimum_segment_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_minimum_segment_tree
// directed and random point updates and range minimum queries with random
// gaps on the input side and random stalls on the result side; a checker
// beside the block shadows the tree and compares every returned minimum
// ----------------------------------------------------------------------------

module tb_range_minimum_segment_tree;

  import rmst_pkg::*;

  localparam int LEAVES     = 1024;
  localparam int LAST_POS   = LEAVES - 1;
  localparam int RAND_ITEMS = 1600;
  // longest busy time of one item, with margin
  localparam int DRAIN_CYCLES = 60;

  localparam logic signed [VAL_W-1:0] MIN_VALUE = 32'sh8000_0000;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_cmd        = CMD_UPDATE;
  logic [POS_W-1:0]        in_position   = '0;
  logic signed [VAL_W-1:0] in_new_value  = '0;
  logic [POS_W-1:0]        in_range_low  = '0;
  logic [POS_W-1:0]        in_range_high = '0;
  logic                    out_stall     = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_minimum;

  // quiet stretches: no gaps and no stalls
  logic quiet_phase = 1'b0;
  int   stall_hold  = 0;

  int mismatch_count;
  int minimums_waiting;
  int minimums_matched;
  int n_updates = 0;
  int n_queries = 0;
  int n_empty   = 0;

  // directed items, sent before the random run
  rmst_item_t directed [$];

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  range_minimum_segment_tree #(.LEAVES(LEAVES)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_position  (in_position),
    .in_new_value (in_new_value),
    .in_range_low (in_range_low),
    .in_range_high(in_range_high),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_minimum  (out_minimum)
  );

  rmst_min_checker #(.LEAVES(LEAVES)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_new_value    (in_new_value),
    .in_range_low    (in_range_low),
    .in_range_high   (in_range_high),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_minimum     (out_minimum),
    .mismatch_count  (mismatch_count),
    .minimums_waiting(minimums_waiting),
    .minimums_matched(minimums_matched)
  );

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // value mix: both extremes, values near zero, full random
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return MIN_VALUE;
    if (r < 16) return TOP_VALUE;
    if (r < 30) return $signed($urandom_range(0, 200)) - 100;
    return $urandom;
  endfunction

  // positions: uniform, with a hot spot at each end of the table
  function automatic int pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 15);
    if (r < 30) return $urandom_range(LAST_POS - 15, LAST_POS);
    return $urandom_range(0, LAST_POS);
  endfunction

  // fields that the operation ignores still carry random bits
  function automatic rmst_item_t mk_update(input int pos,
                                           input logic signed [VAL_W-1:0] value);
    rmst_item_t item;
    item.cmd        = CMD_UPDATE;
    item.position   = POS_W'(pos);
    item.new_value  = value;
    item.range_low  = POS_W'($urandom);
    item.range_high = POS_W'($urandom);
    return item;
  endfunction

  function automatic rmst_item_t mk_query(input int lo, input int hi);
    rmst_item_t item;
    item.cmd        = CMD_QUERY;
    item.position   = POS_W'($urandom);
    item.new_value  = $urandom;
    item.range_low  = POS_W'(lo);
    item.range_high = POS_W'(hi);
    return item;
  endfunction

  // random query range of one of several shapes
  function automatic rmst_item_t pick_query();
    int r;
    int a;
    int b;
    r = $urandom_range(0, 99);
    a = $urandom_range(0, LAST_POS);
    b = $urandom_range(0, LAST_POS);
    if (r < 30) begin
      // narrow window
      b = (a + 8 > LAST_POS) ? LAST_POS : a + int'($urandom_range(0, 8));
      return mk_query(a, b);
    end
    if (r < 58) return (a <= b) ? mk_query(a, b) : mk_query(b, a);
    if (r < 72) return mk_query(0, a);
    if (r < 85) return mk_query(a, LAST_POS);
    if (r < 91) return mk_query(a, a);
    if (r < 94) return mk_query(0, LAST_POS);
    // low above high: empty range
    if (a == b) b = (a == 0) ? LAST_POS : 0;
    return (a > b) ? mk_query(a, b) : mk_query(b, a);
  endfunction

  // append one item to the directed list
  function automatic void queue_item(input rmst_item_t item);
    directed.insert(directed.size(), item);
  endfunction

  // present one item and hold it until the block takes it
  task automatic push_item(input rmst_item_t item, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= item.cmd;
    in_position   <= item.position;
    in_new_value  <= item.new_value;
    in_range_low  <= item.range_low;
    in_range_high <= item.range_high;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (item.cmd == CMD_UPDATE) n_updates++;
    else begin
      n_queries++;
      if (item.range_low > item.range_high) n_empty++;
    end
  endtask

  // result side back-pressure: random stall bursts, none in quiet stretches
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (quiet_phase) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= pick_gap();
    end else begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 8);
    end
  end

  // stimulus and verdict
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // untouched tree, then empty range
    queue_item(mk_query(0, LAST_POS));
    queue_item(mk_query(5, 3));
    // both value extremes at both table ends
    queue_item(mk_update(0, MIN_VALUE));
    queue_item(mk_update(LAST_POS, TOP_VALUE));
    queue_item(mk_update(512, -1));
    queue_item(mk_update(1, 0));
    queue_item(mk_query(0, 0));
    queue_item(mk_query(LAST_POS, LAST_POS));
    queue_item(mk_query(0, LAST_POS));
    queue_item(mk_query(1, LAST_POS));
    // positions never written keep the top value
    queue_item(mk_query(513, LAST_POS - 1));
    queue_item(mk_query(LAST_POS, 0));
    // overwrite the global minimum
    queue_item(mk_update(0, 100));
    queue_item(mk_query(0, LAST_POS));
    queue_item(mk_update(LAST_POS - 1, MIN_VALUE + 1));
    queue_item(mk_query(600, LAST_POS));
    queue_item(mk_query(512, 512));
    queue_item(mk_query(1000, 1000));
    // alternating bit patterns in position and value
    queue_item(mk_update('h155, 32'sh5555_5555));
    queue_item(mk_update('h2AA, 32'shAAAA_AAAA));
    queue_item(mk_query('h155, 'h2AA));
    queue_item(mk_query('h156, 'h2A9));
    queue_item(mk_query(2, 511));
    queue_item(mk_update(LAST_POS, MIN_VALUE));
    queue_item(mk_query(0, LAST_POS));

    foreach (directed[i]) push_item(directed[i], pick_gap());

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // every fourth block of a hundred items runs without idling
      quiet_phase <= ((n / 100) % 4 == 3);
      // update-heavy at first so the tree fills, even mix afterwards
      if ($urandom_range(0, 99) < ((n < 300) ? 75 : 50))
        push_item(mk_update(pick_position(), pick_value()), pick_gap());
      else
        push_item(pick_query(), pick_gap());
    end
    in_valid    <= 1'b0;
    quiet_phase <= 1'b0;

    // let the last counts settle, drain the results, then the busy tail
    @(posedge clk);
    while (minimums_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (minimums_waiting != 0)
      $display("%0t: minimums left over, expected 0, actual %0d", $time, minimums_waiting);
    $display("covered %0d updates and %0d queries (%0d with an empty range)",
             n_updates, n_queries, n_empty);
    $display("%0d minimums matched, %0d mismatches", minimums_matched, mismatch_count);
    if (mismatch_count == 0 && minimums_waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard, several times the slowest correct run
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
